// ===== src/eaa_pkg.sv =====
// Shared types, codes and the alpha blend function for the ellipse alpha accumulator.
// No dependencies.
package eaa_pkg;

    // pixel engine operations
    localparam logic [1:0] PX_NONE = 2'd0;
    localparam logic [1:0] PX_CLR  = 2'd1;
    localparam logic [1:0] PX_DARK = 2'd2;
    localparam logic [1:0] PX_PEEK = 2'd3;

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;

    localparam int unsigned SPAN_W = 16;  // signed span limit / delta

    typedef struct packed {
        logic       vld;
        logic [1:0] op;
    } t_px_ctl;

    // a += ((step >> (a >> 4)) * (255 - a)) >> 8, clamped to 255
    function automatic logic [7:0] f_blend(input logic [7:0] a, input logic [9:0] step);
        logic [9:0]  d;
        logic [17:0] m;
        logic [10:0] n;
        d = step >> a[7:4];
        m = 18'(d) * 18'(8'd255 - a);
        n = 11'(a) + 11'(m[17:8]);
        return (n > 11'd255) ? 8'd255 : n[7:0];
    endfunction

endpackage

// ===== src/eaa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module eaa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/eaa_pix.sv =====
// Pixel engine: owns the alpha store, does clear writes, peeks and darken read-modify-writes.
// Depends on eaa_pkg and eaa_ram.
module eaa_pix
    import eaa_pkg::*;
#(
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_px_ctl                  i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [9:0]               i_step,
    output logic                     o_busy,
    output logic [7:0]               o_rdata
);
    localparam int unsigned AW = $clog2(DEPTH);

    logic          r_s1_vld;
    logic [1:0]    r_s1_op;
    logic [AW-1:0] r_s1_addr;
    logic [7:0]    w_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;

    // stage 1 writes back the darkened pixel; no two requests in flight share an address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.vld && (i_ctl.op == PX_DARK);
        end
        r_s1_op   <= i_ctl.op;
        r_s1_addr <= i_addr;
    end

    always_comb begin
        if (r_s1_vld && (r_s1_op == PX_DARK)) begin
            w_we    = 1'b1;
            w_waddr = r_s1_addr;
            w_wdata = f_blend(w_rdata, i_step);
        end else begin
            w_we    = i_ctl.vld && (i_ctl.op == PX_CLR);
            w_waddr = i_addr;
            w_wdata = 8'd0;
        end
    end

    eaa_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_addr),
        .o_rdata(w_rdata)
    );

    assign o_busy  = r_s1_vld;
    assign o_rdata = w_rdata;
endmodule

// ===== src/eaa_span.sv =====
// Span search unit: counts the row half span down until the point lies inside the ellipse.
// Depends on eaa_pkg.
module eaa_span
    import eaa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SPAN_W-1:0] i_lim,
    input  logic [6:0]               i_y,
    input  logic [13:0]              i_sw,
    input  logic [13:0]              i_sh,
    input  logic [27:0]              i_prod,
    output logic                     o_done,
    output logic signed [SPAN_W-1:0] o_lim
);
    localparam logic [2:0] SP_IDLE = 3'd0;
    localparam logic [2:0] SP_YY   = 3'd1;
    localparam logic [2:0] SP_ROWT = 3'd2;
    localparam logic [2:0] SP_CHK  = 3'd3;
    localparam logic [2:0] SP_MUL  = 3'd4;
    localparam logic [2:0] SP_CMP  = 3'd5;

    logic [2:0]               r_st;
    logic signed [SPAN_W-1:0] r_lim;
    logic [6:0]               r_y;
    logic [13:0]              r_yy;
    logic [27:0]              r_rowt;
    logic [29:0]              r_sq;
    logic [43:0]              r_lhs;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= SP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                SP_IDLE: begin
                    if (i_start) begin
                        r_lim <= i_lim;
                        r_y   <= i_y;
                        r_st  <= SP_YY;
                    end
                end
                SP_YY: begin
                    r_yy <= 14'(r_y) * 14'(r_y);
                    r_st <= SP_ROWT;
                end
                SP_ROWT: begin
                    r_rowt <= 28'(r_yy) * 28'(i_sw);
                    r_st   <= SP_CHK;
                end
                SP_CHK: begin
                    // non-positive candidate is taken as it is
                    if (r_lim <= 0) begin
                        r_done <= 1'b1;
                        r_st   <= SP_IDLE;
                    end else begin
                        r_sq <= 30'(r_lim[14:0]) * 30'(r_lim[14:0]);
                        r_st <= SP_MUL;
                    end
                end
                SP_MUL: begin
                    r_lhs <= 44'(r_sq) * 44'(i_sh);
                    r_st  <= SP_CMP;
                end
                SP_CMP: begin
                    if ((45'(r_lhs) + 45'(r_rowt)) <= 45'(i_prod)) begin
                        r_done <= 1'b1;
                        r_st   <= SP_IDLE;
                    end else begin
                        r_lim <= r_lim - SPAN_W'(1);
                        r_st  <= SP_CHK;
                    end
                end
                default: begin
                    r_st <= SP_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_lim  = r_lim;
endmodule

// ===== src/ellipse_alpha_accumulate.sv =====
// Top level of the ellipse alpha accumulator: command sequencer, configuration and result register.
// Depends on eaa_pkg, eaa_pix, eaa_span.
//
// Keeps an 8-bit alpha image of up to MAX_SIDE x MAX_SIDE pixels in one synchronous RAM
// (row stride image_width). Each input word is a command: clear, fill ellipse or read pixel;
// each gives exactly one output word {status, alpha_out}. One command is worked at a time;
// s_tready is high only while the sequencer is idle, and a finished result may sit in the
// output register while the next command is taken. Work is paced by the single RAM write port
// and the span search unit: a clear writes one entry a cycle, a fill darkens one covered pixel
// a cycle (2w+1 on the diameter row) with a row base step per row, and each row of the half
// height waits for a span search, which repeats its check for each span decrement.
// After reset the block sweeps the whole store to zero before s_tready first rises;
// configuration writes are taken throughout.
module ellipse_alpha_accumulate
    import eaa_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd[1:0] pos_x[8:2] pos_y[15:9] half_w[22:16] half_h[29:23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // alpha_out[7:0] status[8]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);
    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [31:0] MS    = MAX_SIDE;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CLR   = 4'd2;
    localparam logic [3:0] ST_PEEK  = 4'd3;
    localparam logic [3:0] ST_PWAIT = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_PROD  = 4'd6;
    localparam logic [3:0] ST_RBASE = 4'd7;
    localparam logic [3:0] ST_ROW   = 4'd8;
    localparam logic [3:0] ST_SRCH  = 4'd9;
    localparam logic [3:0] ST_SWAIT = 4'd10;
    localparam logic [3:0] ST_DRAIN = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    // configuration
    logic [7:0] r_cfg_w, r_cfg_h;
    logic [9:0] r_cfg_step;
    logic [7:0] w_w, w_h;

    // sequencer
    logic [3:0]  r_st;
    logic [6:0]  r_cx, r_cy, r_ew, r_eh;
    logic [13:0] r_sw, r_sh;
    logic [27:0] r_prod;
    logic signed [SPAN_W-1:0] r_lw, r_delta;
    logic [6:0]  r_y, r_row_y, r_x, r_x_hi;
    logic        r_diam, r_second;
    logic [AW-1:0] r_rowbase, r_cnt;
    logic [7:0]  r_res_alpha;
    logic        r_res_st;

    // output register
    logic        r_out_vld;
    logic [15:0] r_out_data;

    // incoming word fields
    logic [1:0] w_cmd;
    logic [6:0] w_px, w_py, w_hw, w_hh;

    logic          w_acc;
    t_px_ctl       w_px_ctl;
    logic [AW-1:0] w_px_addr;
    logic          w_busy;
    logic [7:0]    w_rdata;
    logic          w_sp_start, w_sp_done;
    logic signed [SPAN_W-1:0] w_sp_lim_in, w_sp_lim;
    logic [6:0]    w_span_new;

    assign w_cmd = s_tdata[1:0];
    assign w_px  = s_tdata[8:2];
    assign w_py  = s_tdata[15:9];
    assign w_hw  = s_tdata[22:16];
    assign w_hh  = s_tdata[29:23];

    // sizes above MAX_SIDE act as MAX_SIDE
    assign w_w = (32'(r_cfg_w) > MS) ? MS[7:0] : r_cfg_w;
    assign w_h = (32'(r_cfg_h) > MS) ? MS[7:0] : r_cfg_h;

    assign s_tready = (r_st == ST_IDLE);
    assign w_acc    = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 8'd128;
            r_cfg_h    <= 8'd128;
            r_cfg_step <= 10'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_cfg_w    <= i_cfg_wdata[7:0];
                CFG_HEIGHT: r_cfg_h    <= i_cfg_wdata[7:0];
                CFG_STEP:   r_cfg_step <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // half span of the row just found; a non-positive limit gives the centre pixel alone
    assign w_span_new  = (w_sp_lim > 0) ? w_sp_lim[6:0] : 7'd0;
    assign w_sp_lim_in = r_lw - r_delta + SPAN_W'(1);
    assign w_sp_start  = (r_st == ST_SRCH);

    // pixel engine requests
    always_comb begin
        w_px_ctl  = '{vld: 1'b0, op: PX_NONE};
        w_px_addr = r_rowbase + AW'(r_x);
        case (r_st)
            ST_INIT, ST_CLR: begin
                w_px_ctl  = '{vld: 1'b1, op: PX_CLR};
                w_px_addr = r_cnt;
            end
            ST_PEEK: begin
                w_px_ctl  = '{vld: 1'b1, op: PX_PEEK};
                w_px_addr = AW'(r_cy) * AW'(w_w) + AW'(r_cx);
            end
            ST_ROW: begin
                w_px_ctl  = '{vld: 1'b1, op: PX_DARK};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_INIT;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // ST_DONE loads the output register itself
            if (m_tready && (r_st != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_st)
                ST_INIT: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_cx        <= w_px;
                        r_cy        <= w_py;
                        r_ew        <= w_hw;
                        r_eh        <= w_hh;
                        r_res_alpha <= 8'd0;
                        r_res_st    <= 1'b0;
                        r_cnt       <= '0;
                        case (w_cmd)
                            CMD_CLEAR: r_st <= ST_CLR;
                            CMD_FILL: begin
                                if ((w_hw > w_px) || (w_hh > w_py)
                                        || ((8'(w_px) + 8'(w_hw)) >= w_w)
                                        || ((8'(w_py) + 8'(w_hh)) >= w_h)) begin
                                    r_res_st <= 1'b1;
                                    r_st     <= ST_DONE;
                                end else begin
                                    r_st <= ST_SQ;
                                end
                            end
                            CMD_READ: begin
                                if ((8'(w_px) >= w_w) || (8'(w_py) >= w_h)) begin
                                    r_res_st <= 1'b1;
                                    r_st     <= ST_DONE;
                                end else begin
                                    r_st <= ST_PEEK;
                                end
                            end
                            default: begin
                                r_res_st <= 1'b1;
                                r_st     <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_CLR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_st <= ST_DRAIN;
                    end
                end
                ST_PEEK: begin
                    r_st <= ST_PWAIT;
                end
                ST_PWAIT: begin
                    r_res_alpha <= w_rdata;
                    r_st        <= ST_DONE;
                end
                ST_SQ: begin
                    r_sw     <= 14'(r_ew) * 14'(r_ew);
                    r_sh     <= 14'(r_eh) * 14'(r_eh);
                    r_lw     <= SPAN_W'(r_ew);
                    r_delta  <= '0;
                    r_row_y  <= r_cy;
                    r_x      <= r_cx - r_ew;
                    r_x_hi   <= r_cx + r_ew;
                    r_diam   <= 1'b1;
                    r_second <= 1'b0;
                    r_st     <= ST_PROD;
                end
                ST_PROD: begin
                    r_prod <= 28'(r_sw) * 28'(r_sh);
                    r_st   <= ST_RBASE;
                end
                ST_RBASE: begin
                    r_rowbase <= AW'(r_row_y) * AW'(w_w);
                    r_st      <= ST_ROW;
                end
                ST_ROW: begin
                    if (r_x != r_x_hi) begin
                        r_x <= r_x + 7'd1;
                    end else if (r_diam) begin
                        // diameter row done, walk the rows away from the centre
                        r_diam <= 1'b0;
                        r_y    <= 7'd1;
                        r_st   <= (r_eh == 7'd0) ? ST_DRAIN : ST_SRCH;
                    end else if (!r_second) begin
                        r_second <= 1'b1;
                        r_row_y  <= r_cy + r_y;
                        r_x      <= r_cx - (r_x_hi - r_cx);
                        r_st     <= ST_RBASE;
                    end else begin
                        r_second <= 1'b0;
                        if (r_y == r_eh) begin
                            r_st <= ST_DRAIN;
                        end else begin
                            r_y  <= r_y + 7'd1;
                            r_st <= ST_SRCH;
                        end
                    end
                end
                ST_SRCH: begin
                    r_st <= ST_SWAIT;
                end
                ST_SWAIT: begin
                    if (w_sp_done) begin
                        r_lw    <= w_sp_lim;
                        r_delta <= r_lw - w_sp_lim;
                        r_row_y <= r_cy - r_y;
                        r_x     <= r_cx - w_span_new;
                        r_x_hi  <= r_cx + w_span_new;
                        r_st    <= ST_RBASE;
                    end
                end
                ST_DRAIN: begin
                    // last write-back must land before the result is shown
                    if (!w_busy) begin
                        r_st <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || m_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= {7'd0, r_res_st, r_res_alpha};
                        r_st       <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    eaa_pix #(.DEPTH(DEPTH)) u_pix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_px_ctl),
        .i_addr (w_px_addr),
        .i_step (r_cfg_step),
        .o_busy (w_busy),
        .o_rdata(w_rdata)
    );

    eaa_span u_span (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sp_start),
        .i_lim  (w_sp_lim_in),
        .i_y    (r_y),
        .i_sw   (r_sw),
        .i_sh   (r_sh),
        .i_prod (r_prod),
        .o_done (w_sp_done),
        .o_lim  (w_sp_lim)
    );

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;
endmodule

// ===== src/eaa_checker.sv =====
// Port-level checks for the ellipse alpha accumulator, bound to the top level.
// Depends on ellipse_alpha_accumulate.
module eaa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // a rejected command never reports alpha
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("rejected command with nonzero alpha");

    // reset starts the clearing sweep, no command taken
    a_init: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("ready straight after reset");

    // one command at a time
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");
endmodule

bind ellipse_alpha_accumulate eaa_checker u_eaa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== tb/tb_ellipse_alpha_accumulate.sv =====
// Testbench for ellipse_alpha_accumulate: clear, fill and read commands against an in-bench
// alpha image predictor. Depends on eaa_pkg and the ellipse_alpha_accumulate RTL.
`timescale 1ns / 1ps
module tb_ellipse_alpha_accumulate
    import eaa_pkg::*;
;

    localparam int SIDE = 128;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [6:0] hh;
        logic [6:0] hw;
        logic [6:0] py;
        logic [6:0] px;
        logic [1:0] cmd;
    } t_cmd;

    typedef struct {
        logic [7:0] alpha;
        logic       status;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [9:0]  i_cfg_wdata = '0;

    ellipse_alpha_accumulate uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state: alpha image (clear after reset) and register copies
    logic [7:0] img [SIDE*SIDE] = '{default: 8'd0};
    int         img_w = 128, img_h = 128;
    int         step_amt = 64;

    t_cmd pending_cmds [$];
    t_res expected_words [$];
    int   n_errors = 0;
    int   cycles = 0;
    bit   hold_sink = 1'b0;   // long receiver hold-off request

    function automatic int eff(int v);
        return v > SIDE ? SIDE : v;
    endfunction

    function automatic void darken_px(int x, int y);
        int w, h, idx, a, d, n;
        w = eff(img_w);
        h = eff(img_h);
        if (x < 0 || y < 0 || x >= w || y >= h) return;
        idx = y * w + x;
        a = img[idx];
        d = (step_amt & 10'h3FF) >> (a >> 4);
        n = a + ((d * (255 - a)) >> 8);
        img[idx] = n > 255 ? 8'd255 : 8'(n);
    endfunction

    // returns status of a fill, updating the image
    function automatic bit paint_ellipse(int cx, int cy, int ew, int eh);
        int w, h, lw, dl, lim;
        longint sw, sh, prod, sy;
        w = eff(img_w);
        h = eff(img_h);
        sw = ew * ew;
        sh = eh * eh;
        prod = sw * sh;
        lw = ew;
        dl = 0;
        if (cx - ew < 0 || cx + ew >= w || cy - eh < 0 || cy + eh >= h) return 1'b1;
        for (int x = -ew; x <= ew; x++) darken_px(cx + x, cy);
        for (int y = 1; y <= eh; y++) begin
            lim = lw - (dl - 1);
            sy = y * y;
            // count down while outside the ellipse
            while (lim > 0) begin
                if (longint'(lim) * lim * sh + sy * sw <= prod) break;
                lim--;
            end
            dl = lw - lim;
            lw = lim;
            darken_px(cx, cy - y);
            darken_px(cx, cy + y);
            for (int x = 1; x <= lw; x++) begin
                darken_px(cx + x, cy - y);
                darken_px(cx + x, cy + y);
                darken_px(cx - x, cy - y);
                darken_px(cx - x, cy + y);
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_word(t_cmd c);
        t_res r;
        int w, h;
        r.alpha = '0;
        r.status = 1'b0;
        w = eff(img_w);
        h = eff(img_h);
        case (c.cmd)
            CMD_CLEAR: foreach (img[i]) img[i] = '0;
            CMD_FILL:  r.status = paint_ellipse(c.px, c.py, c.hw, c.hh);
            CMD_READ: begin
                if (c.px >= w || c.py >= h) r.status = 1'b1;
                else r.alpha = img[c.py * w + c.px];
            end
            default:   r.status = 1'b1;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // driver: one word from the queue, random gap before each
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_words.push_back(predict_word(t_cmd'(s_tdata[29:0])));
                void'(pending_cmds.pop_front());
                src_gap = $urandom_range(0, 12);
                if (src_gap == 0 && pending_cmds.size() != 0) begin
                    s_tdata <= {2'b00, pending_cmds[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (src_gap > 0) src_gap--;
                else if (pending_cmds.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, pending_cmds[0]};
                end
            end
        end
    end

    // sink stall counter
    int sink_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                sink_gap = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) sink_gap = 0;
            end else if (sink_gap > 0) sink_gap--;
            m_tready <= (sink_gap == 0 || (m_tvalid && m_tready && sink_gap == 0))
                        && !hold_sink && !(m_tvalid && m_tready && sink_gap != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, -1);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[7:0] != want.alpha) report_mismatch("alpha_out", m_tdata[7:0], want.alpha);
                if (m_tdata[8] != want.status) report_mismatch("status", m_tdata[8], want.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_cmd mk(logic [1:0] c, int x, int y, int w, int h);
        t_cmd r;
        r.cmd = c; r.px = 7'(x); r.py = 7'(y); r.hw = 7'(w); r.hh = 7'(h);
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);   // a rejected word can still be in flight
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= 10'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  img_w = val & 8'hFF;
            CFG_HEIGHT: img_h = val & 8'hFF;
            default:    step_amt = val & 10'h3FF;
        endcase
    endtask

    // mostly small fills that fit, some in-range reads, some noise
    task automatic queue_random(int n);
        int w, h, x, y, ew, eh, k;
        w = eff(img_w);
        h = eff(img_h);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k < 9 && w > 0 && h > 0) begin
                ew = $urandom_range(0, (w - 1) / 2 < 9 ? (w - 1) / 2 : 9);
                eh = $urandom_range(0, (h - 1) / 2 < 9 ? (h - 1) / 2 : 9);
                x = $urandom_range(ew, w - 1 - ew);
                y = $urandom_range(eh, h - 1 - eh);
                pending_cmds.push_back(mk(CMD_FILL, x, y, ew, eh));
            end else if (k < 16 && w > 0 && h > 0) begin
                pending_cmds.push_back(mk(CMD_READ, $urandom_range(0, w - 1),
                                          $urandom_range(0, h - 1), $urandom, $urandom));
            end else if (k < 19) begin
                // any field values: mostly rejected fills or out-of-range reads
                pending_cmds.push_back(mk($urandom_range(1, 2), $urandom, $urandom,
                                          $urandom, $urandom));
            end else begin
                pending_cmds.push_back(mk(2'd3, $urandom, $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at default geometry
        pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_FILL, 0, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_FILL, 5, 5, 5, 5));
        pending_cmds.push_back(mk(CMD_FILL, 5, 5, 5, 5));
        pending_cmds.push_back(mk(CMD_READ, 5, 5, 0, 0));
        pending_cmds.push_back(mk(CMD_FILL, 20, 40, 12, 1));   // wide, flat
        pending_cmds.push_back(mk(CMD_FILL, 40, 20, 1, 12));   // tall, thin: rows with centre only
        pending_cmds.push_back(mk(CMD_FILL, 63, 63, 63, 63));  // largest that fits
        pending_cmds.push_back(mk(CMD_READ, 127, 127, 127, 127));
        pending_cmds.push_back(mk(CMD_FILL, 127, 127, 127, 127)); // outside
        pending_cmds.push_back(mk(CMD_FILL, 64, 64, 64, 0));      // just outside on right
        pending_cmds.push_back(mk(2'd3, 127, 127, 127, 127));     // unknown command
        pending_cmds.push_back(mk(CMD_READ, 63, 63, 0, 0));
        pending_cmds.push_back(mk(CMD_CLEAR, 127, 127, 127, 127));
        pending_cmds.push_back(mk(CMD_READ, 63, 63, 0, 0));
        wait_drained();

        // maximum step and zero step
        write_reg(CFG_STEP, 1023);
        pending_cmds.push_back(mk(CMD_FILL, 3, 3, 2, 3));
        pending_cmds.push_back(mk(CMD_FILL, 3, 3, 2, 3));
        pending_cmds.push_back(mk(CMD_READ, 3, 3, 0, 0));
        queue_random(20);
        wait_drained();
        write_reg(CFG_STEP, 0);
        pending_cmds.push_back(mk(CMD_FILL, 3, 3, 2, 3));
        pending_cmds.push_back(mk(CMD_READ, 3, 3, 0, 0));
        wait_drained();

        // zero geometry rejects everything, then oversized acts as full side
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 0);
        pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_FILL, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_WIDTH, 255);
        write_reg(CFG_HEIGHT, 200);
        write_reg(CFG_STEP, $urandom_range(1, 1023));
        queue_random(30);
        // receiver holds off while the sender keeps offering
        hold_sink = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_sink = 1'b0;
        wait_drained();

        // narrow odd geometry, changed stride
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 128);
        write_reg(CFG_STEP, 300);
        queue_random(15);
        wait_drained();
        write_reg(CFG_WIDTH, 37);
        write_reg(CFG_HEIGHT, 1);
        queue_random(15);
        wait_drained();
        write_reg(CFG_WIDTH, 23);
        write_reg(CFG_HEIGHT, 29);
        write_reg(CFG_STEP, $urandom_range(0, 1023));
        queue_random(45);
        wait_drained();

        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
